// ===== hdl/crc16fr_pkg.sv =====
// ----------------------------------------------------------------------------
// crc16fr_pkg
// Shared types, codes and the CRC byte update for the frame receiver.
// ----------------------------------------------------------------------------
package crc16fr_pkg;

    // queue size and payload limit; port widths are built around these
    localparam int QUEUE_DEPTH = 4;
    localparam int MAX_PAYLOAD = 256;

    typedef enum logic [2:0] {
        ACT_BYTE = 3'd0,
        ACT_TICK = 3'd1,
        ACT_RST  = 3'd2,
        ACT_READ = 3'd3,
        ACT_POP  = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_QUEUED  = 3'd1,
        EV_CRC     = 3'd2,
        EV_FOREIGN = 3'd3,
        EV_FULL    = 3'd4,
        EV_LONG    = 3'd5,
        EV_TIMEOUT = 3'd6
    } event_t;

    typedef enum logic [2:0] {
        CFG_HDR1  = 3'd0,
        CFG_HDR2  = 3'd1,
        CFG_OWN   = 3'd2,
        CFG_BCAST = 3'd3,
        CFG_TMO   = 3'd4
    } cfg_idx_t;

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // one byte of reflected CRC-16, eight shift steps
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== hdl/crc16fr_ram.sv =====
// ----------------------------------------------------------------------------
// crc16fr_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module crc16fr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hdl/crc16_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// crc16_frame_receiver
// Framed byte-stream receiver with CRC-16 (reflected 0xA001) check and a
// small queue of received frames that software reads bytewise and pops.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  in word  | in_valid, in_stall, action, data_byte,    | in
//           | byte_index                                |
//  out word | out_valid, out_stall, byte_taken, ...     | out
//  config   | cfg_we, cfg_index, cfg_data               | in
//
// One word per cycle, back to back while the output is not stalled. A word
// accepted at an edge lands in the result stage at that edge together with the
// payload RAM read; its result then moves into the output register, or into a
// skid register that backs the output when that is full and stalled;
// the input stalls while the skid holds a word, or while a result-stage word
// meets a full, stalled output. Reset needs no clearing pass; stored frames
// are undefined until written.
// ----------------------------------------------------------------------------
module crc16_frame_receiver
    import crc16fr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  action,
    input  logic [7:0]  data_byte,
    input  logic [7:0]  byte_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        byte_taken,
    output logic [2:0]  frame_event,
    output logic        head_valid,
    output logic [7:0]  head_address,
    output logic [7:0]  head_command,
    output logic [8:0]  head_length,
    output logic [7:0]  head_byte,
    output logic [2:0]  frames_waiting,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    localparam int SLOTS  = QUEUE_DEPTH + 1;
    localparam int SW     = $clog2(SLOTS);
    localparam int PW     = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int CW     = $clog2(MAX_PAYLOAD + 1);
    localparam int DEPTH  = SLOTS * MAX_PAYLOAD;
    localparam int AW     = $clog2(DEPTH);
    localparam int HW     = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [3:0] {
        PH_HDR1, PH_HDR2, PH_ADDR, PH_CMD, PH_LENLO, PH_LENHI, PH_PAY,
        PH_CRCLO, PH_CRCHI
    } phase_t;

    // configuration
    logic [7:0]  hdr1_reg, hdr2_reg, own_reg, bcast_reg;
    logic [15:0] tmo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr1_reg  <= 8'hAA;
            hdr2_reg  <= 8'h55;
            own_reg   <= 8'h01;
            bcast_reg <= 8'hFF;
            tmo_reg   <= 16'd100;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HDR1:  hdr1_reg  <= cfg_data[7:0];
                CFG_HDR2:  hdr2_reg  <= cfg_data[7:0];
                CFG_OWN:   own_reg   <= cfg_data[7:0];
                CFG_BCAST: bcast_reg <= cfg_data[7:0];
                CFG_TMO:   tmo_reg   <= cfg_data;
                default:   ;
            endcase
        end
    end

    // parser state
    phase_t      phase_reg, phase_next;
    logic [7:0]  faddr_reg, faddr_next, fcmd_reg, fcmd_next, crclo_reg, crclo_next;
    logic [15:0] flen_reg, flen_next, crc_reg, crc_next, idle_reg, idle_next;
    logic [CW-1:0] pcnt_reg, pcnt_next;
    logic [SW-1:0] head_reg, head_next;
    logic [HW-1:0] held_reg, held_next;

    // slot descriptors: small, read at head only, kept in flops
    logic [7:0] sl_addr [SLOTS];
    logic [7:0] sl_cmd  [SLOTS];
    logic [8:0] sl_len  [SLOTS];

    logic take;
    assign take = in_valid && !in_stall;

    logic [SW-1:0] fill_slot;
    logic [SW:0]   fill_sum;
    assign fill_sum  = {1'b0, head_reg} + {{(SW+1-HW){1'b0}}, held_reg};
    assign fill_slot = (fill_sum >= (SW+1)'(SLOTS)) ? SW'(fill_sum - (SW+1)'(SLOTS))
                                                    : fill_sum[SW-1:0];

    logic         taken_c, st_we, pay_we;
    logic [2:0]   ev_c;
    logic [15:0]  rx_crc, flen_full;

    always_comb
    begin
        phase_next = phase_reg;
        faddr_next = faddr_reg;
        fcmd_next  = fcmd_reg;
        flen_next  = flen_reg;
        crclo_next = crclo_reg;
        crc_next   = crc_reg;
        idle_next  = idle_reg;
        pcnt_next  = pcnt_reg;
        head_next  = head_reg;
        held_next  = held_reg;
        taken_c    = 1'b0;
        ev_c       = EV_NONE;
        st_we      = 1'b0;
        pay_we     = 1'b0;
        rx_crc     = {data_byte, crclo_reg};
        flen_full  = {data_byte, flen_reg[7:0]};
        if (take)
        begin
            case (action)
                ACT_BYTE:
                begin
                    case (phase_reg)
                        PH_HDR1:
                        begin
                            if (data_byte == hdr1_reg)
                            begin
                                phase_next = PH_HDR2;
                                idle_next  = '0;
                                taken_c    = 1'b1;
                            end
                        end
                        PH_HDR2:
                        begin
                            pcnt_next  = '0;
                            crc_next   = CRC_INIT;
                            crclo_next = '0;
                            idle_next  = '0;
                            if (data_byte == hdr2_reg)
                            begin
                                phase_next = PH_ADDR;
                                taken_c    = 1'b1;
                            end
                            else if (data_byte == hdr1_reg)
                            begin
                                phase_next = PH_HDR2;
                                taken_c    = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_HDR1;
                            end
                        end
                        PH_ADDR:
                        begin
                            taken_c = 1'b1; idle_next = '0;
                            faddr_next = data_byte;
                            crc_next   = crc_byte(CRC_INIT, data_byte);
                            phase_next = PH_CMD;
                        end
                        PH_CMD:
                        begin
                            taken_c = 1'b1; idle_next = '0;
                            fcmd_next  = data_byte;
                            crc_next   = crc_byte(crc_reg, data_byte);
                            phase_next = PH_LENLO;
                        end
                        PH_LENLO:
                        begin
                            taken_c = 1'b1; idle_next = '0;
                            flen_next  = {8'h00, data_byte};
                            crc_next   = crc_byte(crc_reg, data_byte);
                            phase_next = PH_LENHI;
                        end
                        PH_LENHI:
                        begin
                            taken_c = 1'b1; idle_next = '0;
                            flen_next  = flen_full;
                            crc_next   = crc_byte(crc_reg, data_byte);
                            if (flen_full > 16'(MAX_PAYLOAD))
                            begin
                                phase_next = PH_HDR1;
                                pcnt_next  = '0;
                                crc_next   = CRC_INIT;
                                crclo_next = '0;
                                ev_c       = EV_LONG;
                            end
                            else if (flen_full == 16'd0)
                            begin
                                phase_next = PH_CRCLO;
                            end
                            else
                            begin
                                pcnt_next  = '0;
                                phase_next = PH_PAY;
                            end
                        end
                        PH_PAY:
                        begin
                            taken_c = 1'b1; idle_next = '0;
                            pay_we    = 1'b1;
                            pcnt_next = pcnt_reg + 1'b1;
                            crc_next  = crc_byte(crc_reg, data_byte);
                            if (16'(pcnt_next) >= flen_reg)
                            begin
                                phase_next = PH_CRCLO;
                            end
                        end
                        PH_CRCLO:
                        begin
                            taken_c = 1'b1; idle_next = '0;
                            crclo_next = data_byte;
                            phase_next = PH_CRCHI;
                        end
                        PH_CRCHI:
                        begin
                            taken_c = 1'b1;
                            if (rx_crc != crc_reg)
                                ev_c = EV_CRC;
                            else if (faddr_reg != own_reg && faddr_reg != bcast_reg)
                                ev_c = EV_FOREIGN;
                            else if (held_reg >= HW'(QUEUE_DEPTH))
                                ev_c = EV_FULL;
                            else
                            begin
                                ev_c      = EV_QUEUED;
                                st_we     = 1'b1;
                                held_next = held_reg + 1'b1;
                            end
                            phase_next = PH_HDR1;
                            pcnt_next  = '0;
                            crc_next   = CRC_INIT;
                            crclo_next = '0;
                            idle_next  = '0;
                        end
                        default:
                        begin
                            taken_c    = 1'b1;
                            phase_next = PH_HDR1;
                            pcnt_next  = '0;
                            crc_next   = CRC_INIT;
                            crclo_next = '0;
                            idle_next  = '0;
                        end
                    endcase
                end
                ACT_TICK:
                begin
                    if (phase_reg != PH_HDR1)
                    begin
                        idle_next = (idle_reg != 16'hFFFF) ? idle_reg + 1'b1 : idle_reg;
                        if (idle_next > tmo_reg)
                        begin
                            phase_next = PH_HDR1;
                            pcnt_next  = '0;
                            crc_next   = CRC_INIT;
                            crclo_next = '0;
                            idle_next  = '0;
                            ev_c       = EV_TIMEOUT;
                        end
                    end
                end
                ACT_RST:
                begin
                    phase_next = PH_HDR1;
                    pcnt_next  = '0;
                    crc_next   = CRC_INIT;
                    crclo_next = '0;
                    idle_next  = '0;
                end
                ACT_POP:
                begin
                    if (held_reg != '0)
                    begin
                        head_next = (head_reg == SW'(SLOTS - 1)) ? '0 : head_reg + 1'b1;
                        held_next = held_reg - 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR1;
            faddr_reg <= '0;
            fcmd_reg  <= '0;
            flen_reg  <= '0;
            crclo_reg <= '0;
            crc_reg   <= CRC_INIT;
            idle_reg  <= '0;
            pcnt_reg  <= '0;
            head_reg  <= '0;
            held_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            faddr_reg <= faddr_next;
            fcmd_reg  <= fcmd_next;
            flen_reg  <= flen_next;
            crclo_reg <= crclo_next;
            crc_reg   <= crc_next;
            idle_reg  <= idle_next;
            pcnt_reg  <= pcnt_next;
            head_reg  <= head_next;
            held_reg  <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            sl_addr[fill_slot] <= faddr_reg;
            sl_cmd[fill_slot]  <= fcmd_reg;
            sl_len[fill_slot]  <= flen_reg[8:0];
        end
    end

    // payload memory: slot * MAX_PAYLOAD + position
    logic [AW-1:0] waddr, raddr;
    logic [7:0]    rdata;
    assign waddr = AW'(fill_slot * MAX_PAYLOAD) + AW'(pcnt_reg[PW-1:0]);
    assign raddr = AW'(head_next * MAX_PAYLOAD) + AW'(byte_index[PW-1:0]);

    crc16fr_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_pay (
        .clk   (clk),
        .we    (pay_we),
        .waddr (waddr),
        .wdata (data_byte),
        .raddr (raddr),
        .rdata (rdata)
    );

    // result stage: fields fixed now, RAM data arrives next cycle
    logic       r_valid_reg, r_taken_reg, r_rd_reg, r_hv_reg;
    logic [2:0] r_ev_reg;
    logic [HW-1:0] r_held_reg;
    logic [7:0] r_addr_reg, r_cmd_reg;
    logic [8:0] r_len_reg;
    logic       hv_n, rd_n;
    assign hv_n = held_next != '0;
    assign rd_n = (action == ACT_READ) && hv_n && ({1'b0, byte_index} < sl_len[head_next])
                  && (9'(byte_index) < 9'(MAX_PAYLOAD));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            r_valid_reg <= 1'b0;
        else
            r_valid_reg <= take;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            r_taken_reg <= taken_c;
            r_ev_reg    <= ev_c;
            r_hv_reg    <= hv_n;
            r_rd_reg    <= rd_n;
            r_held_reg  <= held_next;
            // a slot being written this cycle cannot be the head unless queue was empty
            r_addr_reg  <= (st_we && held_reg == '0) ? faddr_reg : sl_addr[head_next];
            r_cmd_reg   <= (st_we && held_reg == '0) ? fcmd_reg  : sl_cmd[head_next];
            r_len_reg   <= (st_we && held_reg == '0) ? flen_reg[8:0] : sl_len[head_next];
        end
    end

    typedef struct packed {
        logic       taken;
        logic [2:0] ev;
        logic       hv;
        logic [7:0] addr;
        logic [7:0] cmd;
        logic [8:0] len;
        logic [7:0] hb;
        logic [2:0] held;
    } res_t;

    res_t res_c, out_reg, skid_reg;
    logic out_full_reg;
    logic skid_full_reg;
    assign res_c = '{taken: r_taken_reg, ev: r_ev_reg, hv: r_hv_reg,
                     addr: r_hv_reg ? r_addr_reg : 8'h00,
                     cmd:  r_hv_reg ? r_cmd_reg  : 8'h00,
                     len:  r_hv_reg ? r_len_reg  : 9'h000,
                     hb:   r_rd_reg ? rdata : 8'h00,
                     held: 3'(r_held_reg)};

    // stall while the skid holds a word, or while the result-stage word is
    // headed for the skid (output full and stalled); that keeps the result
    // stage from being overrun, since its data cannot wait there
    assign in_stall = skid_full_reg || (r_valid_reg && out_full_reg && out_stall);

    // output register plus skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_full_reg  <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            if (!out_full_reg || !out_stall)
            begin
                if (skid_full_reg)
                begin
                    out_full_reg  <= 1'b1;
                    skid_full_reg <= r_valid_reg;
                end
                else
                    out_full_reg <= r_valid_reg;
            end
            else if (r_valid_reg)
                skid_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_full_reg || !out_stall)
        begin
            if (skid_full_reg)
            begin
                out_reg <= skid_reg;
                if (r_valid_reg) skid_reg <= res_c;
            end
            else
                out_reg <= res_c;
        end
        else if (r_valid_reg)
            skid_reg <= res_c;
    end

    assign out_valid      = out_full_reg;
    assign byte_taken     = out_reg.taken;
    assign frame_event    = out_reg.ev;
    assign head_valid     = out_reg.hv;
    assign head_address   = out_reg.addr;
    assign head_command   = out_reg.cmd;
    assign head_length    = out_reg.len;
    assign head_byte      = out_reg.hb;
    assign frames_waiting = out_reg.held;

    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= HW'(QUEUE_DEPTH)) else $error("queue count over depth");
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        !(skid_full_reg && out_full_reg && out_stall && r_valid_reg))
        else $error("skid overrun");
    a_store_room: assert property (@(posedge clk) disable iff (!rst_n)
        st_we |-> held_reg < HW'(QUEUE_DEPTH)) else $error("store into full queue");
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> r_valid_reg) else $error("result lost");
endmodule

// ===== dv/tb_crc16_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// tb_crc16_frame_receiver
// Self-checking bench for the CRC-16 framed receiver. Each accepted input
// word is run through a local behavioral copy of the parser and frame queue,
// and the result word is compared against the oldest expected result.
// ----------------------------------------------------------------------------
module tb_crc16_frame_receiver;
    import crc16fr_pkg::*;

    localparam int NSLOT     = 5;          // queue depth plus one fill slot
    localparam int QDEPTH    = 4;
    localparam int MAXPAY    = 256;
    localparam int WD_LIMIT  = 5000;       // idle cycles before giving up

    // parser phases of the local model
    typedef enum int {
        PH_HDR1, PH_HDR2, PH_ADDR, PH_CMD, PH_LENLO, PH_LENHI, PH_PAY,
        PH_CRCLO, PH_CRCHI
    } phase_t;

    typedef struct packed {
        logic        taken;
        event_t      ev;
        logic        hvalid;
        logic [7:0]  haddr;
        logic [7:0]  hcmd;
        logic [8:0]  hlen;
        logic [7:0]  hbyte;
        logic [2:0]  nheld;
    } rx_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  action;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic        out_valid;
    logic        out_stall;
    logic        byte_taken;
    logic [2:0]  frame_event;
    logic        head_valid;
    logic [7:0]  head_address;
    logic [7:0]  head_command;
    logic [8:0]  head_length;
    logic [7:0]  head_byte;
    logic [2:0]  frames_waiting;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    crc16_frame_receiver dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .data_byte      (data_byte),
        .byte_index     (byte_index),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .byte_taken     (byte_taken),
        .frame_event    (frame_event),
        .head_valid     (head_valid),
        .head_address   (head_address),
        .head_command   (head_command),
        .head_length    (head_length),
        .head_byte      (head_byte),
        .frames_waiting (frames_waiting),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // ------------------------------------------------------------------
    // Local model state: register copies, parser, frame queue
    // ------------------------------------------------------------------
    logic [7:0]  reg_hdr1, reg_hdr2, reg_own, reg_bcast;
    logic [15:0] reg_tmo;

    phase_t      ph;
    logic [7:0]  cur_addr, cur_cmd, crc_lo;
    logic [15:0] cur_len, run_crc, idle_cnt;
    int          pay_cnt;
    int          head_slot, held;
    logic [7:0]  slot_addr [NSLOT];
    logic [7:0]  slot_cmd  [NSLOT];
    logic [8:0]  slot_len  [NSLOT];
    logic [7:0]  pay_mem   [NSLOT*MAXPAY];

    rx_result_t  pending_results [$];
    int          n_errors;
    int          n_words;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_cycles;      // receiver hold-off request
    int          quiet_cycles;

    function automatic logic [15:0] crc16_update(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        repeat (8)
        begin
            r = (r >> 1) ^ (r[0] ? CRC_POLY : 16'h0000);
        end
        return r;
    endfunction

    function automatic int fill_slot();
        return (head_slot + held) % NSLOT;
    endfunction

    task automatic clear_parser();
        ph       = PH_HDR1;
        pay_cnt  = 0;
        run_crc  = CRC_INIT;
        crc_lo   = 8'h00;
        idle_cnt = 16'h0000;
    endtask

    task automatic parse_byte(input logic [7:0] b, output logic taken, inout event_t ev);
        int w;
        taken = 1'b0;
        if (ph == PH_HDR1)
        begin
            if (b == reg_hdr1)
            begin
                ph = PH_HDR2;
                idle_cnt = '0;
                taken = 1'b1;
            end
        end
        else if (ph == PH_HDR2)
        begin
            // second header match wins even if both headers are equal
            if (b == reg_hdr2)
            begin
                ph = PH_ADDR;
                idle_cnt = '0;
                taken = 1'b1;
            end
            else
            begin
                clear_parser();
                if (b == reg_hdr1)
                begin
                    ph = PH_HDR2;
                    taken = 1'b1;
                end
            end
        end
        else
        begin
            taken = 1'b1;
            idle_cnt = '0;
            case (ph)
                PH_ADDR:
                begin
                    cur_addr = b;
                    run_crc = crc16_update(CRC_INIT, b);
                    ph = PH_CMD;
                end
                PH_CMD:
                begin
                    cur_cmd = b;
                    run_crc = crc16_update(run_crc, b);
                    ph = PH_LENLO;
                end
                PH_LENLO:
                begin
                    cur_len = {8'h00, b};
                    run_crc = crc16_update(run_crc, b);
                    ph = PH_LENHI;
                end
                PH_LENHI:
                begin
                    cur_len[15:8] = b;
                    run_crc = crc16_update(run_crc, b);
                    if (cur_len > MAXPAY)
                    begin
                        clear_parser();
                        ev = EV_LONG;
                    end
                    else if (cur_len == 0)
                        ph = PH_CRCLO;
                    else
                    begin
                        pay_cnt = 0;
                        ph = PH_PAY;
                    end
                end
                PH_PAY:
                begin
                    if (pay_cnt < MAXPAY)
                        pay_mem[fill_slot()*MAXPAY + pay_cnt] = b;
                    pay_cnt++;
                    run_crc = crc16_update(run_crc, b);
                    if (pay_cnt >= cur_len)
                        ph = PH_CRCLO;
                end
                PH_CRCLO:
                begin
                    crc_lo = b;
                    ph = PH_CRCHI;
                end
                PH_CRCHI:
                begin
                    if ({b, crc_lo} != run_crc)
                        ev = EV_CRC;
                    else if (cur_addr != reg_own && cur_addr != reg_bcast)
                        ev = EV_FOREIGN;
                    else if (held >= QDEPTH)
                        ev = EV_FULL;
                    else
                    begin
                        w = fill_slot();
                        slot_addr[w] = cur_addr;
                        slot_cmd[w]  = cur_cmd;
                        slot_len[w]  = cur_len[8:0];
                        held++;
                        ev = EV_QUEUED;
                    end
                    clear_parser();
                end
                default:
                    clear_parser();
            endcase
        end
    endtask

    // advance the model by one accepted word and queue the expected result
    task automatic predict_word(input logic [2:0] act, input logic [7:0] b,
                                input logic [7:0] idx);
        rx_result_t r;
        r = '0;
        r.ev = EV_NONE;
        case (act)
            ACT_BYTE:
                parse_byte(b, r.taken, r.ev);
            ACT_TICK:
            begin
                if (ph != PH_HDR1)
                begin
                    if (idle_cnt != 16'hFFFF)
                        idle_cnt++;
                    if (idle_cnt > reg_tmo)
                    begin
                        clear_parser();
                        r.ev = EV_TIMEOUT;
                    end
                end
            end
            ACT_RST:
                clear_parser();
            ACT_POP:
            begin
                if (held > 0)
                begin
                    head_slot = (head_slot + 1) % NSLOT;
                    held--;
                end
            end
            default: ;
        endcase
        r.hvalid = (held > 0);
        if (r.hvalid)
        begin
            r.haddr = slot_addr[head_slot];
            r.hcmd  = slot_cmd[head_slot];
            r.hlen  = slot_len[head_slot];
            if (act == ACT_READ && idx < slot_len[head_slot])
                r.hbyte = pay_mem[head_slot*MAXPAY + idx];
        end
        r.nheld = held[2:0];
        pending_results.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Clock, receiver stall, result checker, watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // receiver side: random stall, or a long hold-off when requested
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        rx_result_t got, want;
        got = {byte_taken, event_t'(frame_event), head_valid, head_address,
               head_command, head_length, head_byte, frames_waiting};
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("ERROR: result word with nothing expected: %p", got);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                    begin
                        $display("ERROR: word mismatch");
                        $display("  exp taken=%0d ev=%0d hv=%0d addr=%h cmd=%h",
                                 want.taken, want.ev, want.hvalid, want.haddr, want.hcmd);
                        $display("      len=%0d byte=%h n=%0d",
                                 want.hlen, want.hbyte, want.nheld);
                        $display("  got taken=%0d ev=%0d hv=%0d addr=%h cmd=%h",
                                 got.taken, got.ev, got.hvalid, got.haddr, got.hcmd);
                        $display("      len=%0d byte=%h n=%0d",
                                 got.hlen, got.hbyte, got.nheld);
                    end
                end
            end
        end
    end

    // watchdog: ends the run after a long stretch with no word moving
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driving helpers
    // ------------------------------------------------------------------

    // offer one word, with random sender gaps, and wait until it is taken
    task automatic send_word(input logic [2:0] act, input logic [7:0] b,
                             input logic [7:0] idx);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        action     <= act;
        data_byte  <= b;
        byte_index <= idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_word(act, b, idx);
        n_words++;
    endtask

    // drop valid and let every expected word come back, plus pipeline slack
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // register write, only called when drained
    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_HDR1:  reg_hdr1  = val[7:0];
            CFG_HDR2:  reg_hdr2  = val[7:0];
            CFG_OWN:   reg_own   = val[7:0];
            CFG_BCAST: reg_bcast = val[7:0];
            CFG_TMO:   reg_tmo   = val;
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [7:0] h1, input logic [7:0] h2,
                            input logic [7:0] own, input logic [7:0] bc,
                            input logic [15:0] tmo);
        drain();
        write_reg(CFG_HDR1, {8'h00, h1});
        write_reg(CFG_HDR2, {8'h00, h2});
        write_reg(CFG_OWN, {8'h00, own});
        write_reg(CFG_BCAST, {8'h00, bc});
        write_reg(CFG_TMO, tmo);
    endtask

    // full frame; length above the limit stops after the length field,
    // bad_crc flips one CRC bit, tick_pct sprinkles ticks between bytes
    task automatic send_frame(input logic [7:0] adr, input logic [7:0] cmd,
                              input logic [15:0] len, input bit bad_crc,
                              input int tick_pct);
        logic [15:0] c;
        logic [7:0]  p;
        c = CRC_INIT;
        send_word(ACT_BYTE, reg_hdr1, 8'($urandom));
        send_word(ACT_BYTE, reg_hdr2, 8'($urandom));
        send_word(ACT_BYTE, adr, 8'($urandom));
        c = crc16_update(c, adr);
        send_word(ACT_BYTE, cmd, 8'($urandom));
        c = crc16_update(c, cmd);
        send_word(ACT_BYTE, len[7:0], 8'($urandom));
        c = crc16_update(c, len[7:0]);
        send_word(ACT_BYTE, len[15:8], 8'($urandom));
        c = crc16_update(c, len[15:8]);
        if (len > MAXPAY)
            return;
        for (int k = 0; k < len; k++)
        begin
            if ($urandom_range(99) < tick_pct)
                send_word(ACT_TICK, 8'($urandom), 8'($urandom));
            p = 8'($urandom);
            send_word(ACT_BYTE, p, 8'($urandom));
            c = crc16_update(c, p);
        end
        if (bad_crc)
            c ^= 16'h1 << $urandom_range(15);
        send_word(ACT_BYTE, c[7:0], 8'($urandom));
        send_word(ACT_BYTE, c[15:8], 8'($urandom));
    endtask

    // read one byte of the head frame, mostly inside its length
    task automatic read_head();
        logic [7:0] i;
        i = (held > 0 && $urandom_range(3) != 0)
            ? 8'($urandom_range(slot_len[head_slot] > 0 ? slot_len[head_slot] - 1 : 0))
            : 8'($urandom);
        send_word(ACT_READ, 8'($urandom), i);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // empty queue reads and pops, unused actions, idle tick and parser reset
    task automatic test_idle_actions();
        send_word(ACT_READ, 8'h00, 8'h00);
        send_word(ACT_POP, 8'hFF, 8'hFF);
        send_word(ACT_TICK, 8'h00, 8'h00);
        send_word(ACT_RST, 8'h00, 8'h00);
        send_word(3'd5, 8'hAA, 8'h00);
        send_word(3'd6, 8'h55, 8'h01);
        send_word(3'd7, 8'hFF, 8'hFF);
        send_word(ACT_BYTE, 8'h00, 8'h00);   // noise, ignored
    endtask

    // each frame outcome but the timeout, header quirks, reads in and past the length
    task automatic test_frame_outcomes();
        send_frame(reg_own, 8'h03, 16'd2, 0, 0);         // queued
        send_word(ACT_READ, 8'h00, 8'h00);
        send_word(ACT_READ, 8'h00, 8'h01);
        send_word(ACT_READ, 8'h00, 8'h02);               // past length
        send_word(ACT_READ, 8'h00, 8'hFF);
        send_frame(reg_bcast, 8'hFF, 16'd0, 0, 0);       // zero length, broadcast
        send_frame(reg_own, 8'h00, 16'd1, 1, 0);         // crc mismatch
        send_frame(8'h42, 8'h10, 16'd1, 0, 0);           // foreign address
        send_frame(reg_own, 8'h01, 16'd257, 0, 0);       // too long
        send_frame(reg_own, 8'h01, 16'hFFFF, 0, 0);      // too long, top value
        send_frame(reg_own, 8'h77, 16'd256, 0, 0);       // largest payload
        send_word(ACT_READ, 8'h00, 8'hFF);
        send_frame(reg_own, 8'h11, 16'd0, 0, 0);         // queue now full
        send_frame(reg_own, 8'h12, 16'd0, 0, 0);         // queue full event
        // second header wrong but equal to the first: stays armed
        send_word(ACT_BYTE, reg_hdr1, 8'h00);
        send_word(ACT_BYTE, reg_hdr1, 8'h00);
        send_word(ACT_BYTE, reg_hdr2, 8'h00);
        send_word(ACT_RST, 8'h00, 8'h00);
        // second header wrong and unrelated: parser drops it
        send_word(ACT_BYTE, reg_hdr1, 8'h00);
        send_word(ACT_BYTE, ~reg_hdr2 ^ reg_hdr1 ? ~reg_hdr2 : 8'h01, 8'h00);
        repeat (5)
            send_word(ACT_POP, 8'h00, 8'h00);
        send_word(ACT_READ, 8'h00, 8'h00);
    endtask

    // timeout at small settings, equal header values, extreme addresses
    task automatic test_timeout_and_regs();
        set_regs(8'h33, 8'h33, 8'h00, 8'h00, 16'd0);
        send_word(ACT_BYTE, 8'h33, 8'h00);
        send_word(ACT_BYTE, 8'h33, 8'h00);       // second header wins
        send_word(ACT_TICK, 8'h00, 8'h00);       // zero timeout drops at once
        send_frame(8'h00, 8'h5A, 16'd1, 0, 0);
        set_regs(8'hFF, 8'h00, 8'hFF, 8'h80, 16'd2);
        send_word(ACT_BYTE, 8'hFF, 8'h00);
        send_word(ACT_BYTE, 8'h00, 8'h00);
        send_word(ACT_BYTE, 8'hFF, 8'h00);
        repeat (3)
            send_word(ACT_TICK, 8'h00, 8'h00);
        send_frame(8'h80, 8'hA5, 16'd3, 0, 50);
        send_word(ACT_POP, 8'h00, 8'h00);
        send_word(ACT_POP, 8'h00, 8'h00);
    endtask

    // top timeout value: ticks on an open frame do not drop it
    task automatic test_timeout_saturation();
        int keep;
        set_regs(8'hAA, 8'h55, 8'h01, 8'hFF, 16'hFFFF);
        keep = send_idle_pct;
        send_idle_pct = 0;
        send_word(ACT_BYTE, reg_hdr1, 8'h00);
        repeat (12)
            send_word(ACT_TICK, 8'h00, 8'h00);
        send_word(ACT_BYTE, reg_hdr2, 8'h00);
        send_word(ACT_RST, 8'h00, 8'h00);
        send_idle_pct = keep;
    endtask

    // receiver holds off while words keep coming, then sender waits it out
    task automatic test_backpressure();
        drain();
        hold_cycles = 300;
        repeat (12)
            send_word(ACT_TICK, 8'($urandom), 8'($urandom));
        send_frame(reg_own, 8'h21, 16'd4, 0, 0);
        drain();
        read_head();
        send_word(ACT_POP, 8'h00, 8'h00);
    endtask

    // random traffic: mostly well-formed frames with random content
    task automatic test_random_traffic(input int n_items, input int tick_pct);
        int goal;
        int pick;
        logic [7:0] a;
        goal = n_words + n_items;
        while (n_words < goal)
        begin
            pick = $urandom_range(99);
            a = ($urandom_range(3) == 0) ? reg_bcast
              : ($urandom_range(5) == 0) ? 8'($urandom) : reg_own;
            if (pick < 40)
                send_frame(a, 8'($urandom),
                           ($urandom_range(19) == 0) ? 16'($urandom_range(48))
                                                     : 16'($urandom_range(6)),
                           $urandom_range(9) == 0, tick_pct);
            else if (pick < 45)
                send_frame(a, 8'($urandom), ($urandom_range(1) == 0) ? 16'($urandom)
                                                                     : 16'd257, 0, 0);
            else if (pick < 60)
                read_head();
            else if (pick < 72)
                send_word(ACT_POP, 8'($urandom), 8'($urandom));
            else if (pick < 80)
                send_word(ACT_TICK, 8'($urandom), 8'($urandom));
            else if (pick < 83)
                send_word(ACT_RST, 8'($urandom), 8'($urandom));
            else if (pick < 86)
                send_word(3'($urandom_range(5, 7)), 8'($urandom), 8'($urandom));
            else if (pick < 92)
            begin
                // broken start: header then junk
                send_word(ACT_BYTE, reg_hdr1, 8'($urandom));
                send_word(ACT_BYTE, 8'($urandom), 8'($urandom));
            end
            else
                send_word(ACT_BYTE, 8'($urandom), 8'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = ACT_BYTE;
        data_byte = 8'h00;
        byte_index = 8'h00;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_HDR1;
        cfg_data = 16'h0000;
        n_errors = 0;
        n_words = 0;
        hold_cycles = 0;
        quiet_cycles = 0;
        send_idle_pct = 12;
        recv_idle_pct = 45;

        // model reset state
        reg_hdr1 = 8'hAA;
        reg_hdr2 = 8'h55;
        reg_own = 8'h01;
        reg_bcast = 8'hFF;
        reg_tmo = 16'd100;
        clear_parser();
        cur_addr = '0;
        cur_cmd = '0;
        cur_len = '0;
        head_slot = 0;
        held = 0;
        foreach (slot_addr[i])
        begin
            slot_addr[i] = '0;
            slot_cmd[i] = '0;
            slot_len[i] = '0;
        end
        foreach (pay_mem[i])
            pay_mem[i] = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_idle_actions();
        test_frame_outcomes();
        test_timeout_and_regs();
        test_backpressure();

        // random phases, each under a different setting and idle mix
        set_regs(8'hAA, 8'h55, 8'h01, 8'hFF, 16'd100);
        test_random_traffic(15, 3);
        set_regs(8'h00, 8'hFF, 8'h00, 8'h80, 16'd3);
        send_idle_pct = 45;
        recv_idle_pct = 12;
        test_random_traffic(15, 10);
        set_regs(8'hFF, 8'h00, 8'hFF, 8'h00, 16'd1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(15, 5);

        test_timeout_saturation();

        drain();
        repeat (10) @(posedge clk);
        if (n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
